[src/bsc_pkg.sv]
package bsc_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_AC1     = 3'd0,
        REG_AC2     = 3'd1,
        REG_AC3     = 3'd2,
        REG_AC4     = 3'd3,
        REG_AC5_AC6 = 3'd4,
        REG_B1_B2   = 3'd5,
        REG_MC_MD   = 3'd6,
        REG_OSS     = 3'd7
    } cfg_idx_t;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Divider geometry: temperature |MC*2048| / |X1+MD|, pressure B7' / B4
    localparam int T_NUM_W = 27;
    localparam int T_DEN_W = 19;
    localparam int P_NUM_W = 32;
    localparam int P_DEN_W = 17;

    // Datasheet constants
    localparam logic signed [27:0] B6_OFFSET  = 28'sd4000;
    localparam logic [31:0]        B4_OFFSET  = 32'd32768;
    localparam logic [15:0]        B7_SCALE   = 16'd50000;
    localparam logic signed [12:0] P_C1       = 13'sd3038;
    localparam logic signed [14:0] P_C2       = -15'sd7357;
    localparam logic signed [45:0] P_C3       = 46'sd3791;

    // Calibration set as seen by the datapath
    typedef struct packed {
        logic signed [15:0] ac1;
        logic signed [15:0] ac2;
        logic signed [15:0] ac3;
        logic [15:0]        ac4;
        logic [15:0]        ac5;
        logic [15:0]        ac6;
        logic signed [15:0] b1;
        logic signed [15:0] b2;
        logic signed [15:0] mc;
        logic signed [15:0] md;
        logic [1:0]         oss;
    } cal_t;

    // Sideband riding along the temperature divider
    typedef struct packed {
        logic signed [17:0] x1;
        logic [18:0]        up;
        logic               neg;
        logic               err;
    } tside_t;

    // Sideband riding along the pressure divider
    typedef struct packed {
        logic signed [15:0] temp;
        logic               err;
        logic               b7_hi;
    } pside_t;

endpackage

[src/bsc_tfront.sv]
module bsc_tfront (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic [15:0]                       raw_temperature,
    input  logic [23:0]                       raw_pressure_bytes,
    input  bsc_pkg::cal_t                     cal,
    output logic                              out_valid,
    output logic [bsc_pkg::T_NUM_W-1:0]       out_num,
    output logic [bsc_pkg::T_DEN_W-1:0]       out_den,
    output bsc_pkg::tside_t                   out_side
);

    logic               va_reg, vb_reg, vc_reg;
    logic signed [33:0] prod_a_reg;
    logic [18:0]        up_a_reg, up_b_reg;
    logic signed [17:0] x1_b_reg;
    logic signed [18:0] den_b_reg;
    logic [bsc_pkg::T_NUM_W-1:0] num_c_reg;
    logic [bsc_pkg::T_DEN_W-1:0] den_c_reg;
    bsc_pkg::tside_t    side_c_reg;

    logic signed [16:0] diff_a;
    logic signed [16:0] ac5_s;
    logic [3:0]         up_sh;
    logic [23:0]        up_full;
    logic signed [17:0] x1_b;
    logic signed [18:0] den_b;
    logic [15:0]        mc_mag;
    logic [18:0]        den_mag;

    // Stage A: (UT - AC6) * AC5 and the oversampling shift of UP
    always_comb
    begin
        diff_a  = signed'({1'b0, raw_temperature}) - signed'({1'b0, cal.ac6});
        ac5_s   = signed'({1'b0, cal.ac5});
        up_sh   = 4'd8 - {2'b00, cal.oss};
        up_full = raw_pressure_bytes >> up_sh;
    end

    // Stage B: X1 and the divisor X1 + MD
    always_comb
    begin
        x1_b  = prod_a_reg[32:15];
        den_b = 19'(x1_b) + 19'(cal.md);
    end

    // Stage C: operand magnitudes and quotient sign
    always_comb
    begin
        mc_mag  = cal.mc[15] ? (16'd0 - cal.mc) : cal.mc;
        den_mag = den_b_reg[18] ? (19'd0 - den_b_reg) : den_b_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_a_reg     <= diff_a * ac5_s;
        up_a_reg       <= up_full[18:0];
        x1_b_reg       <= x1_b;
        den_b_reg      <= den_b;
        up_b_reg       <= up_a_reg;
        num_c_reg      <= {mc_mag, 11'b0};
        den_c_reg      <= den_mag;
        side_c_reg.x1  <= x1_b_reg;
        side_c_reg.up  <= up_b_reg;
        side_c_reg.neg <= cal.mc[15] ^ den_b_reg[18];
        side_c_reg.err <= (den_b_reg == 19'sd0);
    end

    assign out_valid = vc_reg;
    assign out_num   = num_c_reg;
    assign out_den   = den_c_reg;
    assign out_side  = side_c_reg;

endmodule

[src/bsc_pdiv.sv]
module bsc_pdiv #(
    parameter int NUM_W  = 32,
    parameter int DEN_W  = 17,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] side,
    output logic              out_valid,
    output logic [NUM_W-1:0]  quo,
    output logic [SIDE_W-1:0] out_side
);

    localparam int ACC_W = DEN_W + NUM_W;

    // acc holds {partial remainder, numerator bits left | quotient bits so far}
    logic [ACC_W-1:0]  acc_reg  [NUM_W];
    logic [DEN_W-1:0]  den_reg  [NUM_W];
    logic [SIDE_W-1:0] side_reg [NUM_W];
    logic [NUM_W-1:0]  vld_reg;

    // One restoring step: bring in a numerator bit, trial subtract
    function automatic logic [ACC_W-1:0] div_step(input logic [ACC_W-1:0] acc,
                                                  input logic [DEN_W-1:0] d);
        logic [DEN_W:0] trial;
        logic           qb;
        trial = {acc[ACC_W-1:NUM_W], acc[NUM_W-1]};
        qb    = (trial >= {1'b0, d});
        if (qb)
        begin
            trial = trial - {1'b0, d};
        end
        return {trial[DEN_W-1:0], acc[NUM_W-2:0], qb};
    endfunction

    for (genvar i = 0; i < NUM_W; i++)
    begin : g_stage
        if (i == 0)
        begin : g_first
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[i] <= 1'b0;
                end
                else
                begin
                    vld_reg[i] <= in_valid;
                end
            end

            always_ff @(posedge clk)
            begin
                acc_reg[i]  <= div_step({{DEN_W{1'b0}}, num}, den);
                den_reg[i]  <= den;
                side_reg[i] <= side;
            end
        end
        else
        begin : g_next
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[i] <= 1'b0;
                end
                else
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end

            always_ff @(posedge clk)
            begin
                acc_reg[i]  <= div_step(acc_reg[i-1], den_reg[i-1]);
                den_reg[i]  <= den_reg[i-1];
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign out_valid = vld_reg[NUM_W-1];
    assign quo       = acc_reg[NUM_W-1][NUM_W-1:0];
    assign out_side  = side_reg[NUM_W-1];

    // Final remainder must be below a nonzero divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[NUM_W-1] && (den_reg[NUM_W-1] != '0)) |->
        (acc_reg[NUM_W-1][ACC_W-1:NUM_W] < den_reg[NUM_W-1]))
        else $error("divider remainder not below divisor");

endmodule

[src/bsc_pcalc.sv]
module bsc_pcalc (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [bsc_pkg::T_NUM_W-1:0]   in_quo,
    input  bsc_pkg::tside_t               in_side,
    input  bsc_pkg::cal_t                 cal,
    output logic                          out_valid,
    output logic [bsc_pkg::P_NUM_W-1:0]   out_num,
    output logic [bsc_pkg::P_DEN_W-1:0]   out_den,
    output bsc_pkg::pside_t               out_side
);

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic err1_reg, err2_reg, err3_reg, err4_reg, err5_reg, err6_reg, err7_reg;
    logic [18:0] up1_reg, up2_reg, up3_reg, up4_reg, up5_reg;
    logic signed [15:0] t2_reg, t3_reg, t4_reg, t5_reg, t6_reg, t7_reg;
    logic signed [27:0] b5_1_reg;
    logic signed [27:0] b6_2_reg;
    logic signed [55:0] sqf_3_reg;
    logic signed [43:0] mac2_3_reg, mac3_3_reg;
    logic signed [59:0] mb2_4_reg, mb1_4_reg;
    logic signed [32:0] x2a_4_reg;
    logic signed [30:0] x1b_4_reg;
    logic [33:0]        x3a_5_reg;
    logic [31:0]        x3b_5_reg;
    logic [31:0]        diff_6_reg;
    logic [16:0]        b4_6_reg, b4_7_reg;
    logic [31:0]        b7_7_reg;

    logic signed [27:0] qs;
    logic signed [27:0] tt;
    logic signed [15:0] t_sat;
    logic signed [43:0] sq;
    logic [33:0]        x3b_sum;
    logic [33:0]        b3_v;
    logic [33:0]        b3_w;
    logic [31:0]        x3b_off;
    logic [47:0]        b4_prod;
    logic [15:0]        k_mul;
    logic [47:0]        b7_prod;

    // P1: signed quotient, B5
    always_comb
    begin
        qs = in_side.neg ? -signed'({1'b0, in_quo}) : signed'({1'b0, in_quo});
    end

    // P2: temperature out and B6
    always_comb
    begin
        tt = (b5_1_reg + 28'sd8) >>> 4;
        if (tt > 28'sd32767)
        begin
            t_sat = 16'sh7FFF;
        end
        else if (tt < -28'sd32768)
        begin
            t_sat = 16'sh8000;
        end
        else
        begin
            t_sat = tt[15:0];
        end
    end

    // P4: B6^2 / 4096
    assign sq = signed'({1'b0, sqf_3_reg[54:12]});

    // P5: B3's X3 and B4's X3 (low bits only matter downstream)
    assign x3b_sum = mb1_4_reg[49:16] + 34'(x1b_4_reg) + 34'd2;

    // P6: B3, UP - B3, B4
    always_comb
    begin
        b3_v    = (34'(cal.ac1) << 2) + x3a_5_reg;
        b3_w    = (b3_v << cal.oss) + 34'd2;
        x3b_off = x3b_5_reg + bsc_pkg::B4_OFFSET;
        b4_prod = x3b_off * cal.ac4;
    end

    // P7: B7
    always_comb
    begin
        k_mul   = bsc_pkg::B7_SCALE >> cal.oss;
        b7_prod = diff_6_reg * k_mul;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        // P1
        b5_1_reg   <= 28'(in_side.x1) + qs;
        up1_reg    <= in_side.up;
        err1_reg   <= in_side.err;
        // P2
        b6_2_reg   <= b5_1_reg - bsc_pkg::B6_OFFSET;
        t2_reg     <= t_sat;
        up2_reg    <= up1_reg;
        err2_reg   <= err1_reg;
        // P3
        sqf_3_reg  <= b6_2_reg * b6_2_reg;
        mac2_3_reg <= cal.ac2 * b6_2_reg;
        mac3_3_reg <= cal.ac3 * b6_2_reg;
        t3_reg     <= t2_reg;
        up3_reg    <= up2_reg;
        err3_reg   <= err2_reg;
        // P4
        mb2_4_reg  <= cal.b2 * sq;
        mb1_4_reg  <= cal.b1 * sq;
        x2a_4_reg  <= mac2_3_reg[43:11];
        x1b_4_reg  <= mac3_3_reg[43:13];
        t4_reg     <= t3_reg;
        up4_reg    <= up3_reg;
        err4_reg   <= err3_reg;
        // P5
        x3a_5_reg  <= mb2_4_reg[44:11] + 34'(x2a_4_reg);
        x3b_5_reg  <= x3b_sum[33:2];
        t5_reg     <= t4_reg;
        up5_reg    <= up4_reg;
        err5_reg   <= err4_reg;
        // P6
        diff_6_reg <= 32'(up5_reg) - b3_w[33:2];
        b4_6_reg   <= b4_prod[31:15];
        t6_reg     <= t5_reg;
        err6_reg   <= err5_reg;
        // P7
        b7_7_reg   <= b7_prod[31:0];
        b4_7_reg   <= b4_6_reg;
        t7_reg     <= t6_reg;
        err7_reg   <= err6_reg | (b4_6_reg == 17'd0);
    end

    // Numerator for the quotient: 2*B7 when it fits, else B7 (doubled after)
    assign out_valid      = v7_reg;
    assign out_num        = b7_7_reg[31] ? b7_7_reg : {b7_7_reg[30:0], 1'b0};
    assign out_den        = b4_7_reg;
    assign out_side.temp  = t7_reg;
    assign out_side.err   = err7_reg;
    assign out_side.b7_hi = b7_7_reg[31];

    a_b4_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (v6_reg && (b4_6_reg == 17'd0)) |=> (v7_reg && err7_reg))
        else $error("zero B4 not flagged");

endmodule

[src/bsc_pfinal.sv]
module bsc_pfinal (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [bsc_pkg::P_NUM_W-1:0]   in_quo,
    input  bsc_pkg::pside_t               in_side,
    output logic                          out_valid,
    output logic signed [15:0]            temperature_tenths,
    output logic signed [20:0]            pressure_pa,
    output logic                          divide_error
);

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic err1_reg, err2_reg, err3_reg;
    logic signed [15:0] t1_reg, t2_reg, t3_reg;
    logic signed [31:0] p1_reg, p2_reg, p3_reg;
    logic signed [47:0] sq2_reg;
    logic signed [46:0] m2_reg;
    logic signed [44:0] x1_3_reg;
    logic signed [30:0] x2_3_reg;
    logic signed [15:0] temp_reg;
    logic signed [20:0] press_reg;
    logic               err_reg;

    logic [31:0]        q;
    logic signed [23:0] ph;
    logic signed [60:0] x1p;
    logic signed [45:0] corr_sum;
    logic signed [45:0] pf;
    logic signed [20:0] p_sat;

    // F1: undo the doubling order of the quotient
    assign q = in_side.b7_hi ? {in_quo[30:0], 1'b0} : in_quo;

    // F2: (p/256)^2 and -7357*p
    assign ph = p1_reg[31:8];

    // F3: X1 * 3038
    assign x1p = sq2_reg * bsc_pkg::P_C1;

    // F4: final correction and saturation
    always_comb
    begin
        corr_sum = 46'(x1_3_reg) + 46'(x2_3_reg) + bsc_pkg::P_C3;
        pf       = 46'(p3_reg) + (corr_sum >>> 4);
        if (pf > 46'sd1048575)
        begin
            p_sat = 21'sh0FFFFF;
        end
        else if (pf < -46'sd1048576)
        begin
            p_sat = 21'sh100000;
        end
        else
        begin
            p_sat = pf[20:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_reg    <= signed'(q);
        t1_reg    <= in_side.temp;
        err1_reg  <= in_side.err;
        sq2_reg   <= ph * ph;
        m2_reg    <= p1_reg * bsc_pkg::P_C2;
        p2_reg    <= p1_reg;
        t2_reg    <= t1_reg;
        err2_reg  <= err1_reg;
        x1_3_reg  <= x1p[60:16];
        x2_3_reg  <= m2_reg[46:16];
        p3_reg    <= p2_reg;
        t3_reg    <= t2_reg;
        err3_reg  <= err2_reg;
        temp_reg  <= err3_reg ? 16'sd0 : t3_reg;
        press_reg <= err3_reg ? 21'sd0 : p_sat;
        err_reg   <= err3_reg;
    end

    assign out_valid          = v4_reg;
    assign temperature_tenths = temp_reg;
    assign pressure_pa        = press_reg;
    assign divide_error       = err_reg;

endmodule

[src/baro_sensor_compensation_core.sv]
// Barometric sensor compensation core (BMP085/BMP180 integer algorithm).
// Channels: pulse start with raw_temperature and raw_pressure_bytes to launch
// one reading; it is taken at any edge where start is high and busy is low.
// busy stays low: the datapath is fully pipelined and takes a reading every
// cycle. Each reading gives one result beat, shown on temperature_tenths,
// pressure_pa and divide_error for one cycle with done high.
// The two one-bit-per-stage dividers make up most of the pipeline from the
// accepting edge to done (27 stages temperature, 32 stages pressure), plus
// 14 arithmetic stages. Throughput: one reading per cycle.
// Calibration: write cfg_data to register cfg_index while cfg_wr_en is high;
// do so only with no reading in flight.
// Reset (rst_n low): calibration clears to zero, oversampling to 1, and all
// readings in flight are dropped.
// The receiver cannot stall; results leave in order, one beat each.
module baro_sensor_compensation_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [15:0]                       raw_temperature,
    input  logic [23:0]                       raw_pressure_bytes,
    input  logic                              cfg_wr_en,
    input  logic [bsc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bsc_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                              done,
    output logic signed [15:0]                temperature_tenths,
    output logic signed [20:0]                pressure_pa,
    output logic                              divide_error
);

    logic signed [15:0] ac1_reg, ac2_reg, ac3_reg;
    logic [15:0]        ac4_reg;
    logic [31:0]        ac5_ac6_reg, b1_b2_reg, mc_md_reg;
    logic [1:0]         oss_reg;

    bsc_pkg::cal_t      cal;
    logic               accept;

    logic                              tf_valid;
    logic [bsc_pkg::T_NUM_W-1:0]       tf_num;
    logic [bsc_pkg::T_DEN_W-1:0]       tf_den;
    bsc_pkg::tside_t                   tf_side;

    logic                              td_valid;
    logic [bsc_pkg::T_NUM_W-1:0]       td_quo;
    logic [$bits(bsc_pkg::tside_t)-1:0] td_side;

    logic                              pc_valid;
    logic [bsc_pkg::P_NUM_W-1:0]       pc_num;
    logic [bsc_pkg::P_DEN_W-1:0]       pc_den;
    bsc_pkg::pside_t                   pc_side;

    logic                              pd_valid;
    logic [bsc_pkg::P_NUM_W-1:0]       pd_quo;
    logic [$bits(bsc_pkg::pside_t)-1:0] pd_side;

    // Always ready: a new reading can enter every cycle
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Calibration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ac1_reg     <= '0;
            ac2_reg     <= '0;
            ac3_reg     <= '0;
            ac4_reg     <= '0;
            ac5_ac6_reg <= '0;
            b1_b2_reg   <= '0;
            mc_md_reg   <= '0;
            oss_reg     <= 2'd1;
        end
        else if (cfg_wr_en)
        begin
            unique case (bsc_pkg::cfg_idx_t'(cfg_index))
                bsc_pkg::REG_AC1:     ac1_reg     <= cfg_data[15:0];
                bsc_pkg::REG_AC2:     ac2_reg     <= cfg_data[15:0];
                bsc_pkg::REG_AC3:     ac3_reg     <= cfg_data[15:0];
                bsc_pkg::REG_AC4:     ac4_reg     <= cfg_data[15:0];
                bsc_pkg::REG_AC5_AC6: ac5_ac6_reg <= cfg_data;
                bsc_pkg::REG_B1_B2:   b1_b2_reg   <= cfg_data;
                bsc_pkg::REG_MC_MD:   mc_md_reg   <= cfg_data;
                bsc_pkg::REG_OSS:     oss_reg     <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        cal.ac1 = ac1_reg;
        cal.ac2 = ac2_reg;
        cal.ac3 = ac3_reg;
        cal.ac4 = ac4_reg;
        cal.ac5 = ac5_ac6_reg[31:16];
        cal.ac6 = ac5_ac6_reg[15:0];
        cal.b1  = b1_b2_reg[31:16];
        cal.b2  = b1_b2_reg[15:0];
        cal.mc  = mc_md_reg[31:16];
        cal.md  = mc_md_reg[15:0];
        cal.oss = oss_reg;
    end

    bsc_tfront u_tfront (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (accept),
        .raw_temperature    (raw_temperature),
        .raw_pressure_bytes (raw_pressure_bytes),
        .cal                (cal),
        .out_valid          (tf_valid),
        .out_num            (tf_num),
        .out_den            (tf_den),
        .out_side           (tf_side)
    );

    bsc_pdiv #(
        .NUM_W  (bsc_pkg::T_NUM_W),
        .DEN_W  (bsc_pkg::T_DEN_W),
        .SIDE_W ($bits(bsc_pkg::tside_t))
    ) u_tdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (tf_valid),
        .num       (tf_num),
        .den       (tf_den),
        .side      (tf_side),
        .out_valid (td_valid),
        .quo       (td_quo),
        .out_side  (td_side)
    );

    bsc_pcalc u_pcalc (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (td_valid),
        .in_quo    (td_quo),
        .in_side   (bsc_pkg::tside_t'(td_side)),
        .cal       (cal),
        .out_valid (pc_valid),
        .out_num   (pc_num),
        .out_den   (pc_den),
        .out_side  (pc_side)
    );

    bsc_pdiv #(
        .NUM_W  (bsc_pkg::P_NUM_W),
        .DEN_W  (bsc_pkg::P_DEN_W),
        .SIDE_W ($bits(bsc_pkg::pside_t))
    ) u_pdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pc_valid),
        .num       (pc_num),
        .den       (pc_den),
        .side      (pc_side),
        .out_valid (pd_valid),
        .quo       (pd_quo),
        .out_side  (pd_side)
    );

    bsc_pfinal u_pfinal (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (pd_valid),
        .in_quo             (pd_quo),
        .in_side            (bsc_pkg::pside_t'(pd_side)),
        .out_valid          (done),
        .temperature_tenths (temperature_tenths),
        .pressure_pa        (pressure_pa),
        .divide_error       (divide_error)
    );

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && divide_error) |-> ((temperature_tenths == 16'sd0) && (pressure_pa == 21'sd0)))
        else $error("divide error beat carries nonzero results");

endmodule

[tb/tb_top.sv]
module tb_top;

    localparam int LATENCY   = 73;
    localparam int WDOG_MAX  = 2000;
    localparam int N_RANDOM  = 1900;

    // Predicted compensation result for one reading
    typedef struct {
        logic signed [15:0] temp;
        logic signed [20:0] press;
        logic               div_err;
    } comp_result_t;

    // Scoreboard: computes expected readings and checks result beats
    class comp_scoreboard;
        logic signed [15:0] ac1, ac2, ac3;
        logic [15:0]        ac4;
        logic [31:0]        ac56, b12, mcmd;
        logic [1:0]         oss;
        comp_result_t       pending[$];
        int                 errors;

        function new();
            errors = 0;
            ac1 = '0; ac2 = '0; ac3 = '0; ac4 = '0;
            ac56 = '0; b12 = '0; mcmd = '0; oss = 2'd1;
        endfunction

        function void write_reg(bsc_pkg::cfg_idx_t idx, logic [31:0] val);
            case (idx)
                bsc_pkg::REG_AC1:     ac1 = val[15:0];
                bsc_pkg::REG_AC2:     ac2 = val[15:0];
                bsc_pkg::REG_AC3:     ac3 = val[15:0];
                bsc_pkg::REG_AC4:     ac4 = val[15:0];
                bsc_pkg::REG_AC5_AC6: ac56 = val;
                bsc_pkg::REG_B1_B2:   b12 = val;
                bsc_pkg::REG_MC_MD:   mcmd = val;
                bsc_pkg::REG_OSS:     oss = val[1:0];
                default: ;
            endcase
        endfunction

        // >>> on longint is an arithmetic (floor) shift
        function longint sat(longint x, longint lo, longint hi);
            return x < lo ? lo : (x > hi ? hi : x);
        endfunction

        function void note_reading(logic [15:0] ut_in, logic [23:0] bytes);
            comp_result_t r;
            longint ut, up, ac5, ac6, b1, b2, mc, md;
            longint x1, x2, x3, b5, b6, b3, den, p, sq, t;
            logic [31:0] b4, b7, q, tmp;
            ut  = ut_in;
            up  = longint'(bytes) >> (8 - oss);
            ac5 = ac56[31:16];
            ac6 = ac56[15:0];
            b1  = longint'($signed(b12[31:16]));
            b2  = longint'($signed(b12[15:0]));
            mc  = longint'($signed(mcmd[31:16]));
            md  = longint'($signed(mcmd[15:0]));
            r.temp = '0; r.press = '0; r.div_err = 1'b1;
            x1  = ((ut - ac6) * ac5) >>> 15;
            den = x1 + md;
            if (den != 0)
            begin
                x2 = (mc * 2048) / den;
                b5 = x1 + x2;
                t  = sat((b5 + 8) >>> 4, -32768, 32767);
                b6 = b5 - 4000;
                sq = (b6 * b6) >>> 12;
                x1 = (b2 * sq) >>> 11;
                x2 = (longint'(ac2) * b6) >>> 11;
                x3 = x1 + x2;
                b3 = (((longint'(ac1) * 4 + x3) << oss) + 2) >>> 2;
                x1 = (longint'(ac3) * b6) >>> 13;
                x2 = (b1 * sq) >>> 16;
                x3 = (x1 + x2 + 2) >>> 2;
                tmp = 32'(x3 + 32768);
                b4 = (tmp * {16'd0, ac4}) >> 15;
                if (b4 != 0)
                begin
                    tmp = 32'(up - b3);
                    b7  = tmp * (32'd50000 >> oss);
                    if (!b7[31])
                        q = (b7 * 32'd2) / b4;
                    else
                        q = (b7 / b4) * 32'd2;
                    p  = longint'($signed(q));
                    x1 = (p >>> 8) * (p >>> 8);
                    x1 = (x1 * 3038) >>> 16;
                    x2 = (-7357 * p) >>> 16;
                    p  = p + ((x1 + x2 + 3791) >>> 4);
                    r.temp    = 16'(t);
                    r.press   = 21'(sat(p, -1048576, 1048575));
                    r.div_err = 1'b0;
                end
            end
            pending.push_back(r);
        endfunction

        function void check_beat(logic signed [15:0] t, logic signed [20:0] p, logic e);
            comp_result_t x;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result beat t=%0d p=%0d err=%0b",
                         $time, t, p, e);
                errors++;
                return;
            end
            x = pending.pop_front();
            if (t !== x.temp)
            begin
                $display("%0t: temperature exp %0d got %0d", $time, x.temp, t);
                errors++;
            end
            if (p !== x.press)
            begin
                $display("%0t: pressure exp %0d got %0d", $time, x.press, p);
                errors++;
            end
            if (e !== x.div_err)
            begin
                $display("%0t: divide_error exp %0b got %0b", $time, x.div_err, e);
                errors++;
            end
        endfunction
    endclass

    logic                             clk;
    logic                             rst_n;
    logic                             start;
    logic                             busy;
    logic [15:0]                      raw_temperature;
    logic [23:0]                      raw_pressure_bytes;
    logic                             cfg_wr_en;
    logic [bsc_pkg::CFG_IDX_W-1:0]    cfg_index;
    logic [bsc_pkg::CFG_DATA_W-1:0]   cfg_data;
    logic                             done;
    logic signed [15:0]               temperature_tenths;
    logic signed [20:0]               pressure_pa;
    logic                             divide_error;

    comp_scoreboard sb = new();
    int             idle_cycles;

    baro_sensor_compensation_core u_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .busy               (busy),
        .raw_temperature    (raw_temperature),
        .raw_pressure_bytes (raw_pressure_bytes),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .done               (done),
        .temperature_tenths (temperature_tenths),
        .pressure_pa        (pressure_pa),
        .divide_error       (divide_error)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Result monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_beat(temperature_tenths, pressure_pa, divide_error);
            if (done || (start && !busy))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > WDOG_MAX)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // One register write, then cfg_wr_en is dropped before the task returns
    task automatic write_cfg(bsc_pkg::cfg_idx_t idx, logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // One reading beat; start stays high across back-to-back beats
    task automatic send_reading(logic [15:0] ut, logic [23:0] bytes, bit keep);
        start              <= 1'b1;
        raw_temperature    <= ut;
        raw_pressure_bytes <= bytes;
        do @(posedge clk); while (busy);
        sb.note_reading(ut, bytes);
        if (!keep)
            start <= 1'b0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    // Typical datasheet calibration, optionally perturbed
    task automatic load_cal(bit rnd, logic [1:0] os);
        write_cfg(bsc_pkg::REG_AC1, rnd ? $urandom_range(9000, 200) : 408);
        write_cfg(bsc_pkg::REG_AC2, rnd ? -$urandom_range(400, 0) : -72);
        write_cfg(bsc_pkg::REG_AC3, rnd ? -$urandom_range(16000, 12000) : -14383);
        write_cfg(bsc_pkg::REG_AC4, rnd ? $urandom_range(40000, 28000) : 32741);
        write_cfg(bsc_pkg::REG_AC5_AC6, rnd ? {16'($urandom_range(33000, 24000)),
                                               16'($urandom_range(26000, 18000))}
                                            : {16'd32757, 16'd23153});
        write_cfg(bsc_pkg::REG_B1_B2, rnd ? {16'($urandom_range(7000, 5000)),
                                             16'($urandom_range(60, 0))}
                                          : {16'd6190, 16'd4});
        write_cfg(bsc_pkg::REG_MC_MD, rnd ? {16'(-$urandom_range(12000, 8000)),
                                             16'($urandom_range(3000, 2000))}
                                          : {-16'sd8711, 16'd2868});
        write_cfg(bsc_pkg::REG_OSS, os);
    endtask

    // Bursts of readings; a burst with no gap after it runs into the next one
    task automatic random_burst(int n, bit typical);
        int left;
        int blen;
        int gap;
        left = n;
        while (left > 0)
        begin
            blen = $urandom_range(12, 1);
            if (blen > left)
                blen = left;
            gap = ($urandom_range(3, 0) != 0) ? $urandom_range(6, 1) : 0;
            for (int i = 0; i < blen; i++)
                send_reading(typical ? 16'($urandom_range(32000, 22000)) : 16'($urandom),
                             typical ? 24'($urandom_range(24'hB00000, 24'h500000))
                                     : 24'($urandom),
                             (i != blen - 1) || (gap == 0 && left > blen));
            left -= blen;
            if (gap != 0)
                repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        raw_temperature = '0;
        raw_pressure_bytes = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        idle_cycles = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset calibration: every reading has a zero divisor
        send_reading(16'd0, 24'd0, 1);
        send_reading(16'hFFFF, 24'hFFFFFF, 0);
        drain();

        // Datasheet example and field extremes
        load_cal(0, 2'd0);
        send_reading(16'd27898, 24'h5D2300, 1);
        send_reading(16'd0, 24'd0, 1);
        send_reading(16'hFFFF, 24'hFFFFFF, 1);
        send_reading(16'h8000, 24'h800000, 0);
        drain();
        for (int o = 0; o < 4; o++)
        begin
            write_cfg(bsc_pkg::REG_OSS, o);
            send_reading(16'd27898, 24'h5D23C0, 1);
            send_reading(16'hFFFF, 24'hFFFFFF, 1);
            send_reading(16'd0, 24'd0, 0);
            drain();
        end

        // X1+MD zero: AC5=0 makes X1 zero, MD=0
        write_cfg(bsc_pkg::REG_AC5_AC6, {16'd0, 16'd23153});
        write_cfg(bsc_pkg::REG_MC_MD, {-16'sd8711, 16'd0});
        send_reading(16'd1234, 24'h123456, 0);
        drain();
        // B4 zero: AC4=0
        load_cal(0, 2'd3);
        write_cfg(bsc_pkg::REG_AC4, 32'd0);
        send_reading(16'd27898, 24'h5D2300, 0);
        drain();
        // Saturation: extreme calibration
        write_cfg(bsc_pkg::REG_AC1, 32'h7FFF);
        write_cfg(bsc_pkg::REG_AC2, 32'h8000);
        write_cfg(bsc_pkg::REG_AC3, 32'h7FFF);
        write_cfg(bsc_pkg::REG_AC4, 32'hFFFF);
        write_cfg(bsc_pkg::REG_AC5_AC6, 32'hFFFF_0000);
        write_cfg(bsc_pkg::REG_B1_B2, 32'h8000_7FFF);
        write_cfg(bsc_pkg::REG_MC_MD, 32'h7FFF_0001);
        send_reading(16'hFFFF, 24'hFFFFFF, 1);
        send_reading(16'd0, 24'd0, 1);
        send_reading(16'd1, 24'h000100, 0);
        drain();

        // Random phases: mostly plausible calibration, some fully random
        for (int ph = 0; ph < 16; ph++)
        begin
            if (ph % 4 == 3)
            begin
                for (int r = 0; r < 8; r++)
                    write_cfg(bsc_pkg::cfg_idx_t'(r), $urandom);
                random_burst(N_RANDOM / 16, 1'b0);
            end
            else
            begin
                load_cal(ph != 0, 2'($urandom_range(3, 0)));
                random_burst(N_RANDOM / 16, (ph % 2) != 0);
            end
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
